// ----- src/lsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared types, register map and pattern table of the line sensor position
// qualifier.
// ----------------------------------------------------------------------------
package lsq_pkg;

  // Configuration port geometry.
  localparam int CfgAddrWidth = 5;
  localparam int CfgDataWidth = 32;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_BLACK_POLARITY    = 3'd0,
    REG_MARKER_MIN_COUNT  = 3'd1,
    REG_WIDE_MIN_COUNT    = 3'd2,
    REG_REVERSE_HOLD_MS   = 3'd3,
    REG_LOST_HOLD_MS      = 3'd4,
    REG_SEARCH_TIMEOUT_MS = 3'd5
  } reg_index_t;

  // Reset values of the registers.
  localparam logic        BlackPolarityReset   = 1'b1;
  localparam logic [3:0]  MarkerMinCountReset  = 4'd3;
  localparam logic [3:0]  WideMinCountReset    = 4'd5;
  localparam logic [15:0] ReverseHoldMsReset   = 16'd50;
  localparam logic [15:0] LostHoldMsReset      = 16'd200;
  localparam logic [15:0] SearchTimeoutMsReset = 16'd1000;

  // Steering modes.
  typedef enum logic [2:0] {
    MODE_TRACK     = 3'd0,
    MODE_WIDE_HOLD = 3'd1,
    MODE_LOST_HOLD = 3'd2,
    MODE_SEARCH    = 3'd3,
    MODE_STOP      = 3'd4
  } steer_mode_t;

  // Current register settings.
  typedef struct packed {
    logic        black_polarity;
    logic [3:0]  marker_min_count;
    logic [3:0]  wide_min_count;
    logic [15:0] reverse_hold_ms;
    logic [15:0] lost_hold_ms;
    logic [15:0] search_timeout_ms;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [7:0]  sensor_bits;
    logic [31:0] time_ms;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic [7:0]        black_mask;
    logic [3:0]        black_count;
    logic [1:0]        right_black_count;
    logic              marker_seen;
    logic              wide_seen;
    logic              on_line;
    logic              search_expired;
    logic signed [3:0] steer_level;
    logic [2:0]        steer_mode;
  } result_t;

  // Pattern decode of one sample, passed from decode to tracking.
  typedef struct packed {
    logic [7:0]        black_mask;
    logic [3:0]        black_count;
    logic [1:0]        right_black_count;
    logic              marker_seen;
    logic              wide_seen;
    logic              pattern_found;
    logic signed [3:0] pattern_level;
  } decode_t;

  // Tracking status of one sample.
  typedef struct packed {
    logic              on_line;
    logic              search_expired;
    logic signed [3:0] steer_level;
    steer_mode_t       steer_mode;
  } track_t;

  typedef struct packed {
    logic              found;
    logic signed [3:0] level;
  } pattern_t;

  // Map a black mask to its steering level; thirty known patterns.
  function automatic pattern_t pattern_lookup(logic [7:0] mask);
    pattern_t p;
    p.found = 1'b1;
    p.level = 4'sd0;
    case (mask)
      8'h01: p.level = -4'sd4;
      8'h02: p.level = -4'sd3;
      8'h04: p.level = -4'sd2;
      8'h08: p.level = -4'sd1;
      8'h10: p.level = 4'sd1;
      8'h20: p.level = 4'sd2;
      8'h40: p.level = 4'sd3;
      8'h80: p.level = 4'sd4;
      8'h03: p.level = -4'sd4;
      8'h06: p.level = -4'sd3;
      8'h0C: p.level = -4'sd2;
      8'h18: p.level = 4'sd0;
      8'h30: p.level = 4'sd2;
      8'h60: p.level = 4'sd3;
      8'hC0: p.level = 4'sd4;
      8'h07: p.level = -4'sd3;
      8'h0E: p.level = -4'sd2;
      8'h1C: p.level = -4'sd1;
      8'h38: p.level = 4'sd1;
      8'h70: p.level = 4'sd2;
      8'hE0: p.level = 4'sd3;
      8'h0F: p.level = -4'sd2;
      8'h1E: p.level = -4'sd1;
      8'h3C: p.level = 4'sd0;
      8'h78: p.level = 4'sd1;
      8'hF0: p.level = 4'sd2;
      8'h1F: p.level = -4'sd2;
      8'h3E: p.level = -4'sd1;
      8'h7C: p.level = 4'sd1;
      8'hF8: p.level = 4'sd2;
      default: p.found = 1'b0;
    endcase
    return p;
  endfunction

  // Median of three signed levels.
  function automatic logic signed [3:0] median3(logic signed [3:0] a,
                                                logic signed [3:0] b,
                                                logic signed [3:0] c);
    logic signed [3:0] lo;
    logic signed [3:0] hi;
    logic signed [3:0] mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

endpackage

// ----- src/lsq_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_cfg
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module lsq_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsq_pkg::CfgAddrWidth-1:0]    paddr,
  input  logic [lsq_pkg::CfgDataWidth-1:0]    pwdata,
  output logic [lsq_pkg::CfgDataWidth-1:0]    prdata,
  output logic                                pready,
  output lsq_pkg::cfg_t                       cfg
);
  import lsq_pkg::*;

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[CfgAddrWidth-1:2];

  // Register writes; addresses past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.black_polarity    <= BlackPolarityReset;
      cfg.marker_min_count  <= MarkerMinCountReset;
      cfg.wide_min_count    <= WideMinCountReset;
      cfg.reverse_hold_ms   <= ReverseHoldMsReset;
      cfg.lost_hold_ms      <= LostHoldMsReset;
      cfg.search_timeout_ms <= SearchTimeoutMsReset;
    end else if (wr_en) begin
      case (index)
        REG_BLACK_POLARITY:    cfg.black_polarity    <= pwdata[0];
        REG_MARKER_MIN_COUNT:  cfg.marker_min_count  <= pwdata[3:0];
        REG_WIDE_MIN_COUNT:    cfg.wide_min_count    <= pwdata[3:0];
        REG_REVERSE_HOLD_MS:   cfg.reverse_hold_ms   <= pwdata[15:0];
        REG_LOST_HOLD_MS:      cfg.lost_hold_ms      <= pwdata[15:0];
        REG_SEARCH_TIMEOUT_MS: cfg.search_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    prdata = '0;
    case (index)
      REG_BLACK_POLARITY:    prdata = {31'd0, cfg.black_polarity};
      REG_MARKER_MIN_COUNT:  prdata = {28'd0, cfg.marker_min_count};
      REG_WIDE_MIN_COUNT:    prdata = {28'd0, cfg.wide_min_count};
      REG_REVERSE_HOLD_MS:   prdata = {16'd0, cfg.reverse_hold_ms};
      REG_LOST_HOLD_MS:      prdata = {16'd0, cfg.lost_hold_ms};
      REG_SEARCH_TIMEOUT_MS: prdata = {16'd0, cfg.search_timeout_ms};
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- src/lsq_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_decode
// Black mask, channel counts, threshold flags and pattern table lookup.
// ----------------------------------------------------------------------------
module lsq_decode (
  input  logic [7:0]       sensor_bits,
  input  lsq_pkg::cfg_t    cfg,
  output lsq_pkg::decode_t dec
);
  import lsq_pkg::*;

  logic [7:0] mask;
  logic [3:0] cnt;
  logic [1:0] rcnt;
  pattern_t   pat;

  // A channel is black when its bit equals the polarity setting.
  assign mask = cfg.black_polarity ? sensor_bits : ~sensor_bits;

  // Population counts over all channels and over channels five to seven.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'd0, mask[i]};
    end
    rcnt = {1'b0, mask[5]} + {1'b0, mask[6]} + {1'b0, mask[7]};
  end

  assign pat = pattern_lookup(mask);

  always_comb begin
    dec.black_mask        = mask;
    dec.black_count       = cnt;
    dec.right_black_count = rcnt;
    dec.marker_seen       = (cnt >= cfg.marker_min_count);
    dec.wide_seen         = (cnt >= cfg.wide_min_count);
    dec.pattern_found     = pat.found;
    dec.pattern_level     = pat.level;
  end

endmodule

// ----- src/lsq_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsq_track
// Median filter, level shaper with reversal hold, and lost-line timing.
// State advances once per item when enable is high.
// ----------------------------------------------------------------------------
module lsq_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             enable,
  input  lsq_pkg::decode_t dec,
  input  logic [31:0]      time_ms,
  input  lsq_pkg::cfg_t    cfg,
  output lsq_pkg::track_t  status
);
  import lsq_pkg::*;

  // The first matched pattern primes the median, primes the shaper and marks
  // that a line was seen, all at once, so one flag covers all three. The
  // held level always equals the shaped level.
  logic              primed, primed_next;
  logic signed [3:0] hist_old, hist_old_next;
  logic signed [3:0] hist_new, hist_new_next;
  logic signed [3:0] shaped, shaped_next;
  logic              rev_hold, rev_hold_next;
  logic [31:0]       rev_start, rev_start_next;
  logic              inv_run, inv_run_next;
  logic [31:0]       inv_start, inv_start_next;

  logic signed [3:0] target;
  logic [31:0]       rev_elapsed;
  logic [31:0]       inv_elapsed;
  logic              reversal;

  assign rev_elapsed = time_ms - rev_start;

  always_comb begin
    primed_next    = primed;
    hist_old_next  = hist_old;
    hist_new_next  = hist_new;
    shaped_next    = shaped;
    rev_hold_next  = rev_hold;
    rev_start_next = rev_start;
    inv_run_next   = inv_run;
    inv_start_next = inv_start;
    target         = dec.pattern_level;
    reversal       = 1'b0;
    inv_elapsed    = '0;

    status.on_line        = 1'b0;
    status.search_expired = 1'b0;
    status.steer_mode     = MODE_TRACK;

    if (dec.wide_seen) begin
      // Wide pattern: hold the level and reset the invalidity timer.
      inv_run_next      = 1'b0;
      status.steer_mode = MODE_WIDE_HOLD;
    end else if (dec.pattern_found) begin
      // Three-sample median; history is filled with the first level.
      if (!primed) begin
        hist_old_next = dec.pattern_level;
        hist_new_next = dec.pattern_level;
        target        = dec.pattern_level;
      end else begin
        hist_old_next = hist_new;
        hist_new_next = dec.pattern_level;
        target        = median3(hist_old, hist_new, dec.pattern_level);
      end

      // Shaper: step one unit toward the target, via zero on a reversal.
      reversal = ((shaped < 0) && (target > 0)) || ((shaped > 0) && (target < 0));
      if (!primed) begin
        shaped_next = target;
      end else if (rev_hold && (rev_elapsed < {16'd0, cfg.reverse_hold_ms})) begin
        shaped_next = 4'sd0;
      end else begin
        rev_hold_next = 1'b0;
        if (reversal) begin
          shaped_next = (shaped < 0) ? shaped + 4'sd1 : shaped - 4'sd1;
          if (shaped_next == 4'sd0) begin
            rev_hold_next  = 1'b1;
            rev_start_next = time_ms;
          end
        end else if (shaped < target) begin
          shaped_next = shaped + 4'sd1;
        end else if (shaped > target) begin
          shaped_next = shaped - 4'sd1;
        end
      end

      primed_next       = 1'b1;
      inv_run_next      = 1'b0;
      status.on_line    = 1'b1;
      status.steer_mode = MODE_TRACK;
    end else begin
      // No pattern: time since invalidity began picks hold, search or stop.
      inv_run_next = 1'b1;
      if (!inv_run) begin
        inv_start_next = time_ms;
      end
      inv_elapsed = time_ms - inv_start_next;
      if (primed && (inv_elapsed <= {16'd0, cfg.lost_hold_ms})) begin
        status.steer_mode = MODE_LOST_HOLD;
      end else if (inv_elapsed <= {16'd0, cfg.search_timeout_ms}) begin
        status.steer_mode = MODE_SEARCH;
      end else begin
        status.steer_mode     = MODE_STOP;
        status.search_expired = 1'b1;
      end
    end

    status.steer_level = shaped_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      hist_old  <= 4'sd0;
      hist_new  <= 4'sd0;
      shaped    <= 4'sd0;
      rev_hold  <= 1'b0;
      rev_start <= '0;
      inv_run   <= 1'b0;
      inv_start <= '0;
    end else if (enable) begin
      primed    <= primed_next;
      hist_old  <= hist_old_next;
      hist_new  <= hist_new_next;
      shaped    <= shaped_next;
      rev_hold  <= rev_hold_next;
      rev_start <= rev_start_next;
      inv_run   <= inv_run_next;
      inv_start <= inv_start_next;
    end
  end

endmodule

// ----- src/line_sensor_position_qualifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_qualifier
// Qualifies eight-channel line sensor samples into a filtered steering level
// and a steering mode.
// ----------------------------------------------------------------------------
// Every sample item produces exactly one result item. An accepted item sits
// in an input register, is decoded and tracked in a single combinational
// pass, and lands in the result register once that register is free, so a
// new item can be taken every cycle while result_stall is low. The tracking state is
// updated in the same cycle the result is registered, which lets the next
// item use it straight away. When result_stall holds a result, one further
// item is taken into the input register before sample_stall rises. Write
// registers through the APB-style port only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module line_sensor_position_qualifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  lsq_pkg::sample_t                 sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output lsq_pkg::result_t                 result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsq_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [lsq_pkg::CfgDataWidth-1:0] pwdata,
  output logic [lsq_pkg::CfgDataWidth-1:0] prdata,
  output logic                             pready
);
  import lsq_pkg::*;

  cfg_t    cfg;
  sample_t in_item;
  logic    in_full;
  logic    advance;
  logic    take;
  decode_t dec;
  track_t  status;

  // Handshake: the input register moves on when the result register is free.
  assign advance      = in_full && (!result_valid || !result_stall);
  assign sample_stall = in_full && !advance;
  assign take         = sample_valid && !sample_stall;

  lsq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= sample;
    end
  end

  lsq_decode u_decode (
    .sensor_bits (in_item.sensor_bits),
    .cfg         (cfg),
    .dec         (dec)
  );

  lsq_track u_track (
    .clk     (clk),
    .rst     (rst),
    .enable  (advance),
    .dec     (dec),
    .time_ms (in_item.time_ms),
    .cfg     (cfg),
    .status  (status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.black_mask        <= dec.black_mask;
      result.black_count       <= dec.black_count;
      result.right_black_count <= dec.right_black_count;
      result.marker_seen       <= dec.marker_seen;
      result.wide_seen         <= dec.wide_seen;
      result.on_line           <= status.on_line;
      result.search_expired    <= status.search_expired;
      result.steer_level       <= status.steer_level;
      result.steer_mode        <= status.steer_mode;
    end
  end

endmodule

// ----- tb/line_sensor_position_qualifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_qualifier_tb
// Self-checking testbench for the line sensor position qualifier.
// ----------------------------------------------------------------------------
// A driver feeds sensor samples from a queue into the block. Each accepted
// sample also goes through a behavioral predictor that keeps its own copy of
// the register settings and the tracking state. The predictor covers the
// pattern table, the three-sample median, level stepping with the reversal
// hold, and the lost hold, search and stop timing. A monitor compares every
// accepted result, field by field, with the oldest predicted result. The run
// starts with directed samples at the reset settings. Several random phases
// follow, each under its own register settings, mostly with random gaps and
// stalls on both channels.
// ----------------------------------------------------------------------------
module line_sensor_position_qualifier_tb;
  import lsq_pkg::*;

  localparam int CycleLimit = 200000;

  // Known line patterns, first entry in the top byte, with their levels.
  localparam logic [239:0] TrackMasks =
      240'h01020408_10204080_03060C18_3060C007_0E1C3870_E00F1E3C_78F01F3E_7CF8;
  localparam logic [119:0] TrackLevels = 120'hCDEF1234_CDE0234D_EF123EF0_12EF12;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  sample_t                 sample = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  result_t                 result;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [CfgDataWidth-1:0] pwdata = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  // Predictor copy of the registers and of the tracking state.
  cfg_t        cfg_model = {BlackPolarityReset, MarkerMinCountReset, WideMinCountReset,
                            ReverseHoldMsReset, LostHoldMsReset, SearchTimeoutMsReset};
  int          hist_old = 0;
  int          hist_mid = 0;
  int          hist_new = 0;
  bit          median_primed = 1'b0;
  int          held_level = 0;
  bit          ever_valid = 1'b0;
  bit          invalid_running = 1'b0;
  logic [31:0] invalid_start = '0;
  int          shaped_level = 0;
  bit          shaper_primed = 1'b0;
  bit          reversal_hold = 1'b0;
  logic [31:0] reversal_start = '0;

  sample_t     pending_samples[$];
  result_t     expected_results[$];
  result_t     expected_now;
  bit          offering;
  logic [31:0] clock_ms = 32'hFFFF_FA00;
  int          send_idle_pct = 33;
  int          recv_stall_pct = 33;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  line_sensor_position_qualifier u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Position of a mask in the pattern table, or -1 when it is not a line.
  function automatic int table_index(input logic [7:0] mask);
    int i;
    for (i = 0; i < 30; i++) begin
      if (TrackMasks[(29 - i) * 8 +: 8] == mask) return i;
    end
    return -1;
  endfunction

  // Expected result of one sample; advances the predictor state.
  function automatic result_t qualify_sample(input sample_t s);
    result_t           r;
    int                i;
    int                idx;
    int                target;
    int                lo;
    int                hi;
    logic signed [3:0] lv;
    logic [31:0]       elapsed;
    r = '0;
    for (i = 0; i < 8; i++) begin
      if (s.sensor_bits[i] == cfg_model.black_polarity) begin
        r.black_mask[i] = 1'b1;
        r.black_count = r.black_count + 4'd1;
        if (i >= 5) r.right_black_count = r.right_black_count + 2'd1;
      end
    end
    r.marker_seen = (r.black_count >= cfg_model.marker_min_count);
    r.wide_seen = (r.black_count >= cfg_model.wide_min_count);
    idx = table_index(r.black_mask);
    if (r.wide_seen) begin
      // A wide pattern is never looked up; the level is simply held.
      invalid_running = 1'b0;
      r.steer_mode = MODE_WIDE_HOLD;
    end else if (idx >= 0) begin
      lv = TrackLevels[(29 - idx) * 4 +: 4];
      target = lv;
      // Three-sample median; the first valid level fills the whole history.
      if (!median_primed) begin
        hist_old = target;
        hist_mid = target;
        median_primed = 1'b1;
      end else begin
        hist_old = hist_mid;
        hist_mid = hist_new;
      end
      hist_new = target;
      lo = (hist_old < hist_mid) ? hist_old : hist_mid;
      hi = (hist_old < hist_mid) ? hist_mid : hist_old;
      target = (hi < hist_new) ? hi : hist_new;
      target = (lo > target) ? lo : target;
      // Step one unit toward the target, passing through a timed zero hold
      // whenever the direction reverses.
      if (!shaper_primed) begin
        shaped_level = target;
        shaper_primed = 1'b1;
      end else if (reversal_hold &&
                   (s.time_ms - reversal_start) < {16'd0, cfg_model.reverse_hold_ms}) begin
        shaped_level = 0;
      end else begin
        reversal_hold = 1'b0;
        if ((shaped_level < 0 && target > 0) || (shaped_level > 0 && target < 0)) begin
          shaped_level += (shaped_level < 0) ? 1 : -1;
          if (shaped_level == 0) begin
            reversal_hold = 1'b1;
            reversal_start = s.time_ms;
          end
        end else if (shaped_level < target) begin
          shaped_level++;
        end else if (shaped_level > target) begin
          shaped_level--;
        end
      end
      held_level = shaped_level;
      ever_valid = 1'b1;
      invalid_running = 1'b0;
      r.on_line = 1'b1;
      r.steer_mode = MODE_TRACK;
    end else begin
      // No line: the mode depends on the time since the line went away.
      if (!invalid_running) begin
        invalid_running = 1'b1;
        invalid_start = s.time_ms;
      end
      elapsed = s.time_ms - invalid_start;
      if (ever_valid && elapsed <= {16'd0, cfg_model.lost_hold_ms}) begin
        r.steer_mode = MODE_LOST_HOLD;
      end else if (elapsed <= {16'd0, cfg_model.search_timeout_ms}) begin
        r.steer_mode = MODE_SEARCH;
      end else begin
        r.steer_mode = MODE_STOP;
        r.search_expired = 1'b1;
      end
    end
    r.steer_level = held_level[3:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Sample driver: offers the oldest pending item and predicts it on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      offering = sample_valid;
      if (sample_valid && !sample_stall) begin
        expected_results.push_back(qualify_sample(sample));
        void'(pending_samples.pop_front());
        samples_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sample_valid <= 1'b1;
          sample <= pending_samples[0];
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, result);
        mismatch_count++;
      end else begin
        expected_now = expected_results.pop_front();
        check_field("black_mask", expected_now.black_mask, result.black_mask);
        check_field("black_count", expected_now.black_count, result.black_count);
        check_field("right_black_count", expected_now.right_black_count,
                    result.right_black_count);
        check_field("marker_seen", expected_now.marker_seen, result.marker_seen);
        check_field("wide_seen", expected_now.wide_seen, result.wide_seen);
        check_field("on_line", expected_now.on_line, result.on_line);
        check_field("search_expired", expected_now.search_expired,
                    result.search_expired);
        check_field("steer_level", expected_now.steer_level, result.steer_level);
        check_field("steer_mode", expected_now.steer_mode, result.steer_mode);
        results_checked++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // Queue one sample that shows the given black mask under the current polarity.
  task automatic push_mask(input logic [7:0] mask, input logic [31:0] dt);
    sample_t s;
    clock_ms = clock_ms + dt;
    s.sensor_bits = cfg_model.black_polarity ? mask : ~mask;
    s.time_ms = clock_ms;
    pending_samples.push_back(s);
  endtask

  task automatic drain_results();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] kept;
    case (idx)
      REG_BLACK_POLARITY: begin
        kept = value & 32'h1;
        cfg_model.black_polarity = kept[0];
      end
      REG_MARKER_MIN_COUNT: begin
        kept = value & 32'hF;
        cfg_model.marker_min_count = kept[3:0];
      end
      REG_WIDE_MIN_COUNT: begin
        kept = value & 32'hF;
        cfg_model.wide_min_count = kept[3:0];
      end
      REG_REVERSE_HOLD_MS: begin
        kept = value & 32'hFFFF;
        cfg_model.reverse_hold_ms = kept[15:0];
      end
      REG_LOST_HOLD_MS: begin
        kept = value & 32'hFFFF;
        cfg_model.lost_hold_ms = kept[15:0];
      end
      default: begin
        kept = value & 32'hFFFF;
        cfg_model.search_timeout_ms = kept[15:0];
      end
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Back-to-back read of the same address.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != kept) begin
      $display("%0t: register %0d read back mismatch, expected %0d, got %0d",
               $time, idx, kept, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic pol, input logic [3:0] marker,
                                input logic [3:0] wide, input logic [15:0] rev,
                                input logic [15:0] lost, input logic [15:0] search);
    write_reg(REG_BLACK_POLARITY, {31'd0, pol});
    write_reg(REG_MARKER_MIN_COUNT, {28'd0, marker});
    write_reg(REG_WIDE_MIN_COUNT, {28'd0, wide});
    write_reg(REG_REVERSE_HOLD_MS, {16'd0, rev});
    write_reg(REG_LOST_HOLD_MS, {16'd0, lost});
    write_reg(REG_SEARCH_TIMEOUT_MS, {16'd0, search});
  endtask

  // Random traffic: mostly line-following runs, mixed with lost-line
  // stretches, wide patterns, noise and large time jumps.
  task automatic queue_random_items(input int count);
    int         added;
    int         pick;
    int         run_len;
    int         base;
    int         idx;
    int         k;
    int         span;
    logic [7:0] m;
    added = 0;
    span = (int'(cfg_model.lost_hold_ms) + int'(cfg_model.search_timeout_ms)) / 2 + 4;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      run_len = $urandom_range(1, 10);
      if (pick < 60) begin
        base = $urandom_range(0, 29);
        for (k = 0; k < run_len; k++) begin
          idx = ($urandom_range(0, 9) < 7) ? base : $urandom_range(0, 29);
          push_mask(TrackMasks[(29 - idx) * 8 +: 8], $urandom_range(0, 30));
        end
      end else if (pick < 75) begin
        for (k = 0; k < run_len; k++) begin
          do m = 8'($urandom); while (table_index(m) >= 0);
          push_mask(m, $urandom_range(0, span));
        end
      end else if (pick < 85) begin
        for (k = 0; k < run_len; k++) begin
          push_mask(8'($urandom | $urandom), $urandom_range(0, 30));
        end
      end else if (pick < 95) begin
        for (k = 0; k < run_len; k++) begin
          push_mask(8'($urandom), $urandom_range(0, 100));
        end
      end else begin
        run_len = 1;
        push_mask(TrackMasks[$urandom_range(0, 29) * 8 +: 8], $urandom);
      end
      added += run_len;
    end
  endtask

  task automatic run_phase(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = idle_pct;
    queue_random_items(count);
    drain_results();
  endtask

  // Stimulus sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed samples at the reset settings; the timestamp wraps midway.
    push_mask(8'h00, 0);     // no line since reset: search
    push_mask(8'h00, 1500);  // search timed out: stop
    push_mask(8'h01, 0);     // first valid level, taken directly
    push_mask(8'h80, 1);     // median still on the left
    push_mask(8'h80, 1);     // reversal begins, stepping toward zero
    push_mask(8'h80, 1);
    push_mask(8'h80, 1);
    push_mask(8'h80, 1);     // reaches zero, hold starts
    push_mask(8'h80, 10);    // still inside the reversal hold
    push_mask(8'h80, 60);    // hold over, steps to the right
    push_mask(8'hFF, 1);     // all channels black: wide
    push_mask(8'h1F, 1);     // table pattern but wide takes priority
    push_mask(8'h07, 1);     // marker with a valid level
    push_mask(8'h18, 1);
    push_mask(8'h3C, 1);
    push_mask(8'h05, 5);     // line gone: lost hold
    push_mask(8'h05, 200);   // lost hold at its last millisecond
    push_mask(8'h05, 1);     // search
    push_mask(8'h05, 800);   // search timed out: stop
    push_mask(8'hE0, 1);     // right-side pattern
    push_mask(8'hAA, 1);     // new invalid stretch
    push_mask(8'h02, 3);
    drain_results();

    run_phase(450, 33);

    // Inverted polarity, thresholds that always flag or never, zero hold times.
    apply_settings(1'b0, 4'd0, 4'd15, 16'd0, 16'd0, 16'd0);
    run_phase(300, 0);

    // Thresholds at the channel count, largest hold times.
    apply_settings(1'b1, 4'd8, 4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(300, 33);

    // Every sample is wide; marker never flags.
    apply_settings(1'b1, 4'd15, 4'd0, 16'd10, 16'd30, 16'd100);
    run_phase(100, 33);

    // Short hold times so all invalid modes come up often.
    apply_settings(1'b0, 4'd4, 4'd6, 16'd20, 16'd40, 16'd120);
    run_phase(330, 33);

    repeat (4) @(posedge clk);
    $display("Sent %0d samples and checked %0d results over five register settings,",
             samples_sent, results_checked);
    $display("covering both polarities, extreme thresholds and hold times, and all modes.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lsq_pkg.sv
src/lsq_cfg.sv
src/lsq_decode.sv
src/lsq_track.sv
src/line_sensor_position_qualifier.sv
tb/line_sensor_position_qualifier_tb.sv
